// ===== hdl/fpa_pkg.sv =====
`timescale 1ns / 1ps

package fpa_pkg;

  localparam int NUM_BLOCKS = 16;
  localparam int SIZE_BITS  = 16;
  localparam int IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int ACT_W      = 5;
  localparam int CMP_W      = (IDX_W > ACT_W) ? IDX_W : ACT_W;
  localparam int CAP_PORT_W = 16;

  localparam logic CFG_FIT_MODE = 1'b0;
  localparam logic CFG_ACTIVE   = 1'b1;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  typedef enum logic [1:0] {
    MODE_FIRST = 2'd0,
    MODE_BEST  = 2'd1,
    MODE_WORST = 2'd2,
    MODE_SPARE = 2'd3
  } mode_t;

  typedef logic [SIZE_BITS-1:0] size_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [ACT_W-1:0]     act_t;

  typedef struct packed {
    logic  valid;
    mode_t mode;
    size_t req;
    act_t  limit;
    logic  found;
    idx_t  pick;
    size_t best;
    logic  bend;
  } tok_t;

  typedef struct packed {
    logic  en;
    idx_t  idx;
    size_t value;
  } wr_t;

endpackage

// ===== hdl/fit_policy_partition_allocator.sv =====
`timescale 1ns / 1ps

// Keeps the remaining capacity of each memory block in a row of cells.
// An item is taken when start is high and busy is low. A load item writes
// one block's capacity in the cycle it is taken and gives no result; busy
// stays low, so the next item may follow at once. A request item sends a
// search token down the row, one cell per cycle, and each cell compares its
// capacity against the request and the best pick so far under the current
// fit mode. Once the token has left the last cell, the chosen block is
// written back and the result is registered and shown with done high
// for one cycle. Busy stays high from the accepting edge until the result
// is shown, so a new request is not taken before the last one is through.
// The receiver cannot stall and must take each result in the cycle it is
// shown. The configuration port writes fit_mode and active_blocks with
// cfg_we, and must be used only while idle; the block does not enforce it.
// Reset clears all capacities to zero, sets first fit and all blocks
// active, and drops busy and done.

module fit_policy_partition_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic        kind,
  input  logic [3:0]  block_index,
  input  logic [15:0] block_capacity,
  input  logic [15:0] request_size,
  input  logic        batch_end,
  output logic        done,
  output logic        granted,
  output logic [3:0]  granted_block,
  output logic [15:0] capacity_left,
  output logic        batch_done
);

  fpa_pkg::mode_t fit_mode;
  fpa_pkg::act_t  active_blocks;
  fpa_pkg::tok_t  tok [0:fpa_pkg::NUM_BLOCKS];
  fpa_pkg::wr_t   wr;
  fpa_pkg::tok_t  last;
  fpa_pkg::size_t left_next;
  logic           accept;

  assign accept = start && !busy;
  assign last   = tok[fpa_pkg::NUM_BLOCKS];

  assign tok[0] = '{valid: accept && (kind == fpa_pkg::KIND_REQUEST),
                    mode:  fit_mode,
                    req:   fpa_pkg::size_t'(request_size),
                    limit: active_blocks,
                    found: 1'b0,
                    pick:  '0,
                    best:  '0,
                    bend:  batch_end};

  assign left_next = last.best - last.req;

  always_comb begin
    if (last.valid) begin
      wr.en    = last.found;
      wr.idx   = last.pick;
      wr.value = left_next;
    end else begin
      wr.en    = accept && (kind == fpa_pkg::KIND_LOAD) &&
                 (int'(block_index) < fpa_pkg::NUM_BLOCKS);
      wr.idx   = fpa_pkg::idx_t'(block_index);
      wr.value = fpa_pkg::size_t'(block_capacity);
    end
  end

  for (genvar j = 0; j < fpa_pkg::NUM_BLOCKS; j++) begin : g_cell
    fpa_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .cell_id (fpa_pkg::idx_t'(j)),
      .wr      (wr),
      .tok_in  (tok[j]),
      .tok_out (tok[j+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode      <= fpa_pkg::MODE_FIRST;
      active_blocks <= fpa_pkg::act_t'(16);
      busy          <= 1'b0;
      done          <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          fpa_pkg::CFG_FIT_MODE: fit_mode      <= fpa_pkg::mode_t'(cfg_data[1:0]);
          fpa_pkg::CFG_ACTIVE:   active_blocks <= cfg_data;
          default: ;
        endcase
      end
      if (last.valid) begin
        busy <= 1'b0;
      end else if (accept && kind == fpa_pkg::KIND_REQUEST) begin
        busy <= 1'b1;
      end
      done <= last.valid;
    end
    if (last.valid) begin
      granted       <= last.found;
      granted_block <= last.found ? 4'(last.pick) : 4'd0;
      capacity_left <= last.found ? fpa_pkg::CAP_PORT_W'(left_next) : 16'd0;
      batch_done    <= last.bend;
    end
  end

endmodule

// ===== hdl/fpa_cell.sv =====
`timescale 1ns / 1ps

module fpa_cell (
  input  logic          clk,
  input  logic          rst,
  input  fpa_pkg::idx_t cell_id,
  input  fpa_pkg::wr_t  wr,
  input  fpa_pkg::tok_t tok_in,
  output fpa_pkg::tok_t tok_out
);

  fpa_pkg::size_t cap;
  fpa_pkg::tok_t  tok_next;
  logic           active;
  logic           fits;
  logic           take;

  always_comb begin
    active = fpa_pkg::CMP_W'(cell_id) < fpa_pkg::CMP_W'(tok_in.limit);
    fits   = active && (cap >= tok_in.req);
    take   = fits && (!tok_in.found ||
                      (tok_in.mode == fpa_pkg::MODE_BEST  && cap < tok_in.best) ||
                      (tok_in.mode == fpa_pkg::MODE_WORST && cap > tok_in.best));
    tok_next = tok_in;
    if (take) begin
      tok_next.found = 1'b1;
      tok_next.pick  = cell_id;
      tok_next.best  = cap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap           <= '0;
      tok_out.valid <= 1'b0;
    end else begin
      if (wr.en && wr.idx == cell_id) begin
        cap <= wr.value;
      end
      tok_out.valid <= tok_next.valid;
    end
    tok_out.mode  <= tok_next.mode;
    tok_out.req   <= tok_next.req;
    tok_out.limit <= tok_next.limit;
    tok_out.found <= tok_next.found;
    tok_out.pick  <= tok_next.pick;
    tok_out.best  <= tok_next.best;
    tok_out.bend  <= tok_next.bend;
  end

endmodule

// ===== hdl/fpa_checker.sv =====
`timescale 1ns / 1ps

module fpa_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        kind,
  input logic        done,
  input logic        granted,
  input logic [3:0]  granted_block,
  input logic [15:0] capacity_left
);

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while a request is still in the row");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a request in flight");

  a_req_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && kind == fpa_pkg::KIND_REQUEST) |=> busy)
    else $error("accepted request did not raise busy");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !granted) |-> (granted_block == 4'd0 && capacity_left == 16'd0))
    else $error("refused request carries nonzero fields");

endmodule

bind fit_policy_partition_allocator fpa_checker u_fpa_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .kind          (kind),
  .done          (done),
  .granted       (granted),
  .granted_block (granted_block),
  .capacity_left (capacity_left)
);

// ===== tb/sv/tb_fit_policy_partition_allocator.sv =====
`timescale 1ns / 1ps

module tb_fit_policy_partition_allocator;
  import fpa_pkg::*;

  localparam int STALL_LIMIT     = 2000;
  localparam int NUM_PHASES      = 12;
  localparam int ITEMS_PER_PHASE = 130;
  localparam int MAX_PRINTED     = 100;

  typedef struct packed {
    logic   granted;
    idx_t   blk;
    size_t  left;
    logic   bend;
  } grant_t;

  typedef struct packed {
    logic       is_cfg;
    logic       cfg_sel;
    logic [4:0] cfg_val;
    logic       kind;
    idx_t       idx;
    size_t      cap;
    size_t      req;
    logic       bend;
    logic       typed;
    grant_t     exp;
  } stim_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [4:0]  cfg_data = '0;
  logic        start = 1'b0;
  logic        busy;
  logic        kind = 1'b0;
  logic [3:0]  block_index = '0;
  logic [15:0] block_capacity = '0;
  logic [15:0] request_size = '0;
  logic        batch_end = 1'b0;
  logic        done;
  logic        granted;
  logic [3:0]  granted_block;
  logic [15:0] capacity_left;
  logic        batch_done;

  size_t       cap_left [NUM_BLOCKS];
  mode_t       fit_sel = MODE_FIRST;
  logic [4:0]  act_limit = 5'd16;
  grant_t      grants_due [$];
  stim_row_t   directed_rows [$];
  int          mismatches = 0;
  int          stall_cycles = 0;
  bit          allow_gaps = 1'b0;

  fit_policy_partition_allocator u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .start          (start),
    .busy           (busy),
    .kind           (kind),
    .block_index    (block_index),
    .block_capacity (block_capacity),
    .request_size   (request_size),
    .batch_end      (batch_end),
    .done           (done),
    .granted        (granted),
    .granted_block  (granted_block),
    .capacity_left  (capacity_left),
    .batch_done     (batch_done)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTED) begin
      $display("MISMATCH at %0t ns: %s", $time, msg);
    end
    mismatches++;
  endtask

  function automatic stim_row_t load_row(input idx_t idx, input size_t cap);
    stim_row_t r;
    r = '0;
    r.kind = KIND_LOAD;
    r.idx = idx;
    r.cap = cap;
    r.req = size_t'($urandom);
    r.bend = 1'($urandom);
    return r;
  endfunction

  function automatic stim_row_t req_row(input size_t req, input logic bend);
    stim_row_t r;
    r = '0;
    r.kind = KIND_REQUEST;
    r.idx = idx_t'($urandom);
    r.cap = size_t'($urandom);
    r.req = req;
    r.bend = bend;
    return r;
  endfunction

  function automatic stim_row_t req_exp(input size_t req, input logic bend, input logic gr,
                                        input idx_t blk, input size_t left);
    stim_row_t r;
    r = req_row(req, bend);
    r.typed = 1'b1;
    r.exp = '{granted: gr, blk: blk, left: left, bend: bend};
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic sel, input logic [4:0] val);
    stim_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.cfg_sel = sel;
    r.cfg_val = val;
    return r;
  endfunction

  function automatic size_t rand_cap(input bit narrow);
    int pick;
    pick = $urandom_range(0, 9);
    if (narrow) begin
      return size_t'($urandom_range(0, 12));
    end else if (pick == 0) begin
      return '0;
    end else if (pick == 1) begin
      return '1;
    end
    return size_t'($urandom);
  endfunction

  function automatic stim_row_t random_row(input bit narrow);
    int pick;
    size_t req;
    pick = $urandom_range(0, 19);
    if ($urandom_range(0, 99) < 35) begin
      return load_row(idx_t'($urandom), rand_cap(narrow));
    end
    if (pick == 0) begin
      req = '0;
    end else if (pick == 1) begin
      req = '1;
    end else if (pick == 2) begin
      req = size_t'($urandom);
    end else if (narrow) begin
      req = size_t'($urandom_range(0, 6));
    end else begin
      req = size_t'($urandom) & size_t'((32'd1 << $urandom_range(1, 16)) - 1);
    end
    return req_row(req, 1'($urandom));
  endfunction

  // Applies one accepted item to the capacity table and works out the grant it yields.
  task automatic predict_alloc(input stim_row_t r, output logic has_res, output grant_t g);
    int   lim;
    int   pick;
    logic found;
    g = '0;
    has_res = 1'b0;
    found = 1'b0;
    pick = 0;
    if (r.kind == KIND_LOAD) begin
      if (int'(r.idx) < NUM_BLOCKS) begin
        cap_left[r.idx] = r.cap;
      end
    end else begin
      has_res = 1'b1;
      lim = (int'(act_limit) > NUM_BLOCKS) ? NUM_BLOCKS : int'(act_limit);
      for (int j = 0; j < lim; j++) begin
        if (cap_left[j] >= r.req) begin
          if (!found) begin
            found = 1'b1;
            pick = j;
            if (fit_sel != MODE_BEST && fit_sel != MODE_WORST) begin
              break;
            end
          end else if (fit_sel == MODE_BEST && cap_left[j] < cap_left[pick]) begin
            pick = j;
          end else if (fit_sel == MODE_WORST && cap_left[j] > cap_left[pick]) begin
            pick = j;
          end
        end
      end
      if (found) begin
        cap_left[pick] = cap_left[pick] - r.req;
        g.granted = 1'b1;
        g.blk = idx_t'(pick);
        g.left = cap_left[pick];
      end
      g.bend = r.bend;
    end
  endtask

  task automatic run_item(input stim_row_t r);
    logic   accepted;
    logic   has_res;
    grant_t g;
    accepted = 1'b0;
    kind <= r.kind;
    block_index <= r.idx;
    block_capacity <= r.cap;
    request_size <= r.req;
    batch_end <= r.bend;
    while (!accepted) begin
      if (allow_gaps && $urandom_range(0, 5) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      start <= 1'b1;
      @(posedge clk);
      accepted = !busy;
    end
    predict_alloc(r, has_res, g);
    if (has_res) begin
      grants_due.push_back(r.typed ? r.exp : g);
    end
  endtask

  task automatic write_reg(input logic sel, input logic [4:0] val);
    start <= 1'b0;
    while (grants_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (sel == CFG_FIT_MODE) begin
      fit_sel = mode_t'(val[1:0]);
    end else begin
      act_limit = val;
    end
  endtask

  always @(posedge clk) begin : result_check
    grant_t want;
    if (!rst && done === 1'b1) begin
      if (grants_due.size() == 0) begin
        report_mismatch("result with no pending request");
      end else begin
        want = grants_due.pop_front();
        if (granted !== want.granted) begin
          report_mismatch($sformatf("granted %0b, expected %0b", granted, want.granted));
        end
        if (granted_block !== want.blk) begin
          report_mismatch($sformatf("granted_block %0d, expected %0d", granted_block, want.blk));
        end
        if (capacity_left !== want.left) begin
          report_mismatch($sformatf("capacity_left %0d, expected %0d",
                                    capacity_left, want.left));
        end
        if (batch_done !== want.bend) begin
          report_mismatch($sformatf("batch_done %0b, expected %0b", batch_done, want.bend));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done === 1'b1) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("fit_policy_partition_allocator verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int         act_presets [6];
    logic [1:0] mode;
    logic [4:0] act;
    bit         narrow;
    act_presets = '{16, 1, 31, 0, 2, 17};
    foreach (cap_left[i]) cap_left[i] = '0;

    directed_rows.push_back(req_exp(16'h0000, 1'b1, 1'b1, 4'd0, 16'd0));
    directed_rows.push_back(req_exp(16'hFFFF, 1'b0, 1'b0, 4'd0, 16'd0));
    directed_rows.push_back(load_row(4'd0, 16'hFFFF));
    directed_rows.push_back(load_row(4'd15, 16'hFFFF));
    directed_rows.push_back(load_row(4'd5, 16'd100));
    directed_rows.push_back(load_row(4'd9, 16'd50));
    directed_rows.push_back(req_exp(16'hFFFF, 1'b1, 1'b1, 4'd0, 16'd0));
    directed_rows.push_back(req_exp(16'd60, 1'b0, 1'b1, 4'd5, 16'd40));
    directed_rows.push_back(req_exp(16'hFFFF, 1'b0, 1'b1, 4'd15, 16'd0));
    directed_rows.push_back(load_row(4'd15, 16'h8000));
    directed_rows.push_back(cfg_row(CFG_FIT_MODE, {3'b000, MODE_BEST}));
    directed_rows.push_back(req_row(16'd45, 1'b0));
    directed_rows.push_back(req_row(16'd35, 1'b0));
    directed_rows.push_back(req_row(16'd5, 1'b1));
    directed_rows.push_back(cfg_row(CFG_FIT_MODE, {3'b111, MODE_WORST}));
    directed_rows.push_back(req_row(16'd1, 1'b0));
    directed_rows.push_back(cfg_row(CFG_FIT_MODE, {3'b010, MODE_SPARE}));
    directed_rows.push_back(req_row(16'd2, 1'b0));
    directed_rows.push_back(cfg_row(CFG_ACTIVE, 5'd0));
    directed_rows.push_back(req_exp(16'd0, 1'b1, 1'b0, 4'd0, 16'd0));
    directed_rows.push_back(cfg_row(CFG_ACTIVE, 5'd31));
    directed_rows.push_back(req_row(16'd32767, 1'b0));
    directed_rows.push_back(cfg_row(CFG_ACTIVE, 5'd1));
    directed_rows.push_back(req_row(16'd0, 1'b0));
    directed_rows.push_back(req_exp(16'd3, 1'b1, 1'b0, 4'd0, 16'd0));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        write_reg(directed_rows[i].cfg_sel, directed_rows[i].cfg_val);
      end else begin
        run_item(directed_rows[i]);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      mode = (p < 8) ? 2'(p % 4) : 2'($urandom_range(0, 3));
      act = (p < 6) ? 5'(act_presets[p]) : 5'($urandom_range(1, 31));
      narrow = 1'($urandom);
      allow_gaps = (p < NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      write_reg(CFG_FIT_MODE, {3'($urandom), mode});
      write_reg(CFG_ACTIVE, act);
      for (int b = 0; b < NUM_BLOCKS; b++) begin
        run_item(load_row(idx_t'(b), rand_cap(narrow)));
      end
      repeat (ITEMS_PER_PHASE) run_item(random_row(narrow));
    end

    start <= 1'b0;
    while (grants_due.size() != 0) @(posedge clk);
    repeat (NUM_BLOCKS + 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("fit_policy_partition_allocator verification clean");
    end else begin
      $display("fit_policy_partition_allocator verification failed");
    end
    $finish;
  end

endmodule
